// File: src/esod_pkg.sv
// ----------------------------------------------------------------------------
// esod_pkg
// shared types and constants for the encoder speed and open-loop drive core
// ----------------------------------------------------------------------------
`default_nettype none

package esod_pkg;

  localparam int NUM_MOTORS_DEF = 4;
  localparam int TICKS_DEF      = 10;

  localparam int DUTY_FULL   = 1000;
  localparam int FOLD_LIMIT  = 3000;
  localparam int FOLD_BASE   = 6000;
  localparam int SEC_PER_MIN = 60;
  localparam int PPT_RESET   = 138;
  localparam int SPEED_MAX   = 32767;
  localparam int SPEED_NEG   = 32768;

  localparam int ENC_INPUTS  = 4;
  localparam int ENC_W       = 16;
  localparam int TGT_W       = 16;
  localparam int MODE_W      = 8;
  localparam int MOT_W       = 2;
  localparam int ACT_W       = 2;
  localparam int DUTY_W      = 10;
  localparam int SPEED_W     = 16;
  localparam int PEAK_W      = 15;
  localparam int PPT_W       = 16;

  localparam int IN_TDATA_W  = 96;
  localparam int OUT_TDATA_W = 48;

  // serial divider sizing
  localparam int DIV_NW = 25;
  localparam int DIV_DW = 16;

  localparam logic [ACT_W-1:0]  ACT_TICK  = 2'd0;
  localparam logic [ACT_W-1:0]  ACT_SET   = 2'd1;
  localparam logic [ACT_W-1:0]  ACT_STOP  = 2'd2;
  localparam logic [MODE_W-1:0] MODE_SOFT = 8'd0;
  localparam logic [MODE_W-1:0] MODE_HARD = 8'd1;

  typedef enum logic [1:0] {
    KIND_NONE,
    KIND_MEAS,
    KIND_SET,
    KIND_STOP
  } kind_t;

  typedef struct packed {
    logic capture;
    logic dstart;
    logic meas_wb;
    logic set_wb;
    logic stop_wb;
  } cmd_t;

  typedef struct packed {
    kind_t kind;
    logic  idx_last;
    logic  div_busy;
    logic  slot_free;
  } sts_t;

endpackage

`default_nettype wire

// File: src/esod_div.sv
// ----------------------------------------------------------------------------
// esod_div
// restoring unsigned divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
`default_nettype none

module esod_div #(
  parameter int NW = esod_pkg::DIV_NW,
  parameter int DW = esod_pkg::DIV_DW
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          start,
  input  wire logic [NW-1:0] dvd,
  input  wire logic [DW-1:0] dvs,
  output logic               busy,
  output logic [NW-1:0]      quo
);

  localparam int CW = (NW > 1) ? $clog2(NW) : 1;

  logic          busy_r, busy_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [NW-1:0] quo_r, quo_nxt;
  logic [DW-1:0] rem_r, rem_nxt;
  logic [DW-1:0] dvs_r, dvs_nxt;
  logic [DW+1:0] diff;
  logic          fits;

  always_comb begin
    diff     = {1'b0, rem_r, quo_r[NW-1]} - {2'b00, dvs_r};
    fits     = ~diff[DW+1];
    busy_nxt = busy_r;
    cnt_nxt  = cnt_r;
    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    dvs_nxt  = dvs_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      quo_nxt  = dvd;
      rem_nxt  = '0;
      dvs_nxt  = dvs;
    end else if (busy_r) begin
      quo_nxt = {quo_r[NW-2:0], fits};
      rem_nxt = fits ? diff[DW-1:0] : {rem_r[DW-2:0], quo_r[NW-1]};
      cnt_nxt = cnt_r + CW'(1);
      if (cnt_r == CW'(NW - 1)) begin
        busy_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
    end
    cnt_r <= cnt_nxt;
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
    dvs_r <= dvs_nxt;
  end

  assign busy = busy_r;
  assign quo  = quo_r;

endmodule

`default_nettype wire

// File: src/esod_dp.sv
// ----------------------------------------------------------------------------
// esod_dp
// datapath: motor state, speed and duty arithmetic, result register
// ----------------------------------------------------------------------------
`default_nettype none

module esod_dp #(
  parameter int NUM_MOTORS        = esod_pkg::NUM_MOTORS_DEF,
  parameter int TICKS_PER_MEASURE = esod_pkg::TICKS_DEF
) (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire esod_pkg::cmd_t                      cmd,
  output esod_pkg::sts_t                           sts,
  input  wire logic [esod_pkg::IN_TDATA_W-1:0]     in_tdata,
  input  wire logic [esod_pkg::ACT_W-1:0]          in_tuser,
  input  wire logic                                cfg_valid,
  input  wire logic [esod_pkg::PPT_W-1:0]          cfg_data,
  output logic                                     out_tvalid,
  input  wire logic                                out_tready,
  output logic [esod_pkg::OUT_TDATA_W-1:0]         out_tdata,
  output logic                                     out_tlast
);

  localparam int MW  = (NUM_MOTORS > 1) ? $clog2(NUM_MOTORS) : 1;
  localparam int TW  = $clog2(TICKS_PER_MEASURE + 1);
  localparam int NW  = esod_pkg::DIV_NW;
  localparam int DW  = esod_pkg::DIV_DW;
  localparam int EW  = esod_pkg::ENC_W;
  localparam int SW  = esod_pkg::SPEED_W;
  localparam int PW  = esod_pkg::PEAK_W;
  localparam int UW  = esod_pkg::DUTY_W;
  localparam int GW  = esod_pkg::TGT_W;
  localparam int FW  = EW + 2;

  // input unpack
  logic [esod_pkg::MOT_W-1:0]  f_motor;
  logic [GW-1:0]               f_target;
  logic [esod_pkg::MODE_W-1:0] f_mode;
  logic [EW-1:0]               f_enc [esod_pkg::ENC_INPUTS];

  assign f_motor  = in_tdata[1:0];
  assign f_target = in_tdata[17:2];
  assign f_mode   = in_tdata[25:18];
  assign f_enc[0] = in_tdata[41:26];
  assign f_enc[1] = in_tdata[57:42];
  assign f_enc[2] = in_tdata[73:58];
  assign f_enc[3] = in_tdata[89:74];

  // state
  logic [esod_pkg::PPT_W-1:0] ppt_r;
  logic [TW-1:0]              tick_r, tick_nxt;
  logic [SW-1:0]              speed_r [NUM_MOTORS];
  logic [PW-1:0]              peak_r  [NUM_MOTORS];
  logic [1:0]                 pins_r  [NUM_MOTORS];
  logic [UW-1:0]              duty_r  [NUM_MOTORS];

  // captured item
  esod_pkg::kind_t kind_r, kind_nxt;
  logic [EW-1:0]   enc_r [esod_pkg::ENC_INPUTS];
  logic [MW-1:0]   mot_r;
  logic [GW-1:0]   tgt_r;
  logic            hard_r;
  logic [MW-1:0]   idx_r;

  // result register
  logic                               out_valid_r;
  logic [esod_pkg::OUT_TDATA_W-1:0]   out_data_r, out_data_nxt;
  logic                               out_last_r, out_last_nxt;

  // datapath signals
  logic [MW-1:0]  sidx;
  logic [EW-1:0]  cnt_sel;
  logic [FW-1:0]  fold_u, fold_mag;
  logic           meas_neg;
  logic [NW-1:0]  meas_dvd;
  logic [GW-1:0]  tmag;
  logic           set_neg;
  logic [NW-1:0]  set_dvd;
  logic [NW-1:0]  div_dvd;
  logic [DW-1:0]  div_dvs;
  logic           div_busy;
  logic [NW-1:0]  div_quo;
  logic [SW-1:0]  spd_new;
  logic [PW-1:0]  peak_new;
  logic           derr;
  logic [UW-1:0]  duty_new;
  logic [1:0]     pins_new;
  logic           wb_any;
  logic [TW-1:0]  tick_inc;

  assign sidx = (kind_r == esod_pkg::KIND_SET) ? mot_r : idx_r;

  always_comb begin
    cnt_sel = '0;
    for (int k = 0; k < esod_pkg::ENC_INPUTS; k++) begin
      if (int'(idx_r) == k) begin
        cnt_sel = enc_r[k];
      end
    end
  end

  // speed dividend: folded count times 60, as magnitude
  always_comb begin
    if (cnt_sel > EW'(esod_pkg::FOLD_LIMIT)) begin
      fold_u = FW'(esod_pkg::FOLD_BASE) - {2'b00, cnt_sel};
    end else begin
      fold_u = {2'b00, cnt_sel};
    end
    meas_neg = fold_u[FW-1];
    fold_mag = meas_neg ? (FW'(0) - fold_u) : fold_u;
    meas_dvd = NW'(fold_mag) * NW'(esod_pkg::SEC_PER_MIN);
  end

  // duty dividend: 1000 times target, as magnitude
  always_comb begin
    set_neg = tgt_r[GW-1];
    tmag    = set_neg ? (GW'(0) - tgt_r) : tgt_r;
    set_dvd = NW'(tmag) * NW'(esod_pkg::DUTY_FULL);
  end

  always_comb begin
    if (kind_r == esod_pkg::KIND_MEAS) begin
      div_dvd = meas_dvd;
      div_dvs = (ppt_r == '0) ? DW'(1) : DW'(ppt_r);
    end else begin
      div_dvd = set_dvd;
      div_dvs = DW'(peak_r[mot_r]);
    end
  end

  esod_div #(
    .NW (NW),
    .DW (DW)
  ) u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cmd.dstart),
    .dvd   (div_dvd),
    .dvs   (div_dvs),
    .busy  (div_busy),
    .quo   (div_quo)
  );

  // measured speed with saturation, peak tracking
  always_comb begin
    if (!meas_neg) begin
      spd_new = (div_quo > NW'(esod_pkg::SPEED_MAX)) ? SW'(esod_pkg::SPEED_MAX)
                                                       : div_quo[SW-1:0];
    end else begin
      spd_new = (div_quo > NW'(esod_pkg::SPEED_NEG)) ? SW'(esod_pkg::SPEED_NEG)
                                                       : (SW'(0) - div_quo[SW-1:0]);
    end
    if ($signed(spd_new) > $signed({1'b0, peak_r[idx_r]})) begin
      peak_new = spd_new[PW-1:0];
    end else begin
      peak_new = peak_r[idx_r];
    end
  end

  // duty and direction
  always_comb begin
    derr = (peak_r[mot_r] == '0);
    if (derr || (div_quo > NW'(esod_pkg::DUTY_FULL))) begin
      duty_new = '0;
    end else begin
      duty_new = div_quo[UW-1:0];
    end
    pins_new = (!set_neg && (duty_new != '0)) ? 2'b01 : 2'b10;
  end

  // result payload
  always_comb begin
    out_data_nxt = '0;
    out_last_nxt = (idx_r == MW'(NUM_MOTORS - 1));
    out_data_nxt[1:0]   = 2'(sidx);
    out_data_nxt[11:2]  = duty_r[sidx];
    out_data_nxt[13:12] = pins_r[sidx];
    out_data_nxt[29:14] = speed_r[sidx];
    out_data_nxt[44:30] = peak_r[sidx];
    if (cmd.meas_wb) begin
      out_data_nxt[29:14] = spd_new;
      out_data_nxt[44:30] = peak_new;
    end else if (cmd.set_wb) begin
      out_data_nxt[11:2]  = duty_new;
      out_data_nxt[13:12] = pins_new;
      out_data_nxt[45]    = derr;
      out_last_nxt        = 1'b1;
    end else if (cmd.stop_wb) begin
      out_data_nxt[11:2]  = '0;
      out_data_nxt[13:12] = hard_r ? 2'b11 : 2'b00;
    end
  end

  // decode on capture
  assign tick_inc = tick_r + TW'(1);

  always_comb begin
    tick_nxt = tick_r;
    kind_nxt = esod_pkg::KIND_NONE;
    case (in_tuser)
      esod_pkg::ACT_TICK: begin
        if (tick_inc == TW'(TICKS_PER_MEASURE)) begin
          tick_nxt = '0;
          kind_nxt = esod_pkg::KIND_MEAS;
        end else begin
          tick_nxt = tick_inc;
        end
      end
      esod_pkg::ACT_SET: begin
        if (int'(f_motor) < NUM_MOTORS) begin
          kind_nxt = esod_pkg::KIND_SET;
        end
      end
      esod_pkg::ACT_STOP: begin
        if ((f_mode == esod_pkg::MODE_SOFT) || (f_mode == esod_pkg::MODE_HARD)) begin
          kind_nxt = esod_pkg::KIND_STOP;
        end
      end
      default: begin
        kind_nxt = esod_pkg::KIND_NONE;
      end
    endcase
  end

  assign wb_any = cmd.meas_wb | cmd.set_wb | cmd.stop_wb;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ppt_r       <= esod_pkg::PPT_W'(esod_pkg::PPT_RESET);
      tick_r      <= '0;
      kind_r      <= esod_pkg::KIND_NONE;
      idx_r       <= '0;
      out_valid_r <= 1'b0;
      for (int m = 0; m < NUM_MOTORS; m++) begin
        speed_r[m] <= '0;
        peak_r[m]  <= '0;
        pins_r[m]  <= '0;
        duty_r[m]  <= '0;
      end
    end else begin
      if (cfg_valid) begin
        ppt_r <= cfg_data;
      end
      if (cmd.capture) begin
        tick_r <= tick_nxt;
        kind_r <= kind_nxt;
        idx_r  <= '0;
      end else if ((cmd.meas_wb || cmd.stop_wb) && !out_last_nxt) begin
        idx_r <= idx_r + MW'(1);
      end
      if (cmd.meas_wb) begin
        speed_r[idx_r] <= spd_new;
        peak_r[idx_r]  <= peak_new;
      end
      if (cmd.set_wb) begin
        duty_r[mot_r] <= duty_new;
        pins_r[mot_r] <= pins_new;
      end
      if (cmd.stop_wb) begin
        duty_r[idx_r] <= '0;
        pins_r[idx_r] <= hard_r ? 2'b11 : 2'b00;
      end
      if (wb_any) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
    if (cmd.capture) begin
      for (int k = 0; k < esod_pkg::ENC_INPUTS; k++) begin
        enc_r[k] <= f_enc[k];
      end
      mot_r  <= MW'(f_motor);
      tgt_r  <= f_target;
      hard_r <= f_mode[0];
    end
    if (wb_any) begin
      out_data_r <= out_data_nxt;
      out_last_r <= out_last_nxt;
    end
  end

  assign sts.kind      = kind_r;
  assign sts.idx_last  = (idx_r == MW'(NUM_MOTORS - 1));
  assign sts.div_busy  = div_busy;
  assign sts.slot_free = ~out_valid_r | out_tready;

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tlast  = out_last_r;

endmodule

`default_nettype wire

// File: src/esod_ctrl.sv
// ----------------------------------------------------------------------------
// esod_ctrl
// controller: sequences capture, divisions and result write-back
// ----------------------------------------------------------------------------
`default_nettype none

module esod_ctrl (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           in_tvalid,
  output logic                in_tready,
  input  wire esod_pkg::sts_t sts,
  output esod_pkg::cmd_t      cmd
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECODE,
    S_MSTART,
    S_MWAIT,
    S_SSTART,
    S_SWAIT,
    S_STOP
  } state_t;

  state_t state_r, state_nxt;

  always_comb begin
    state_nxt   = state_r;
    cmd         = '0;
    unique case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          cmd.capture = 1'b1;
          state_nxt   = S_DECODE;
        end
      end
      S_DECODE: begin
        unique case (sts.kind)
          esod_pkg::KIND_MEAS: state_nxt = S_MSTART;
          esod_pkg::KIND_SET:  state_nxt = S_SSTART;
          esod_pkg::KIND_STOP: state_nxt = S_STOP;
          default:             state_nxt = S_IDLE;
        endcase
      end
      S_MSTART: begin
        cmd.dstart = 1'b1;
        state_nxt  = S_MWAIT;
      end
      S_MWAIT: begin
        if (!sts.div_busy && sts.slot_free) begin
          cmd.meas_wb = 1'b1;
          state_nxt   = sts.idx_last ? S_IDLE : S_MSTART;
        end
      end
      S_SSTART: begin
        cmd.dstart = 1'b1;
        state_nxt  = S_SWAIT;
      end
      S_SWAIT: begin
        if (!sts.div_busy && sts.slot_free) begin
          cmd.set_wb = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      S_STOP: begin
        if (sts.slot_free) begin
          cmd.stop_wb = 1'b1;
          if (sts.idx_last) begin
            state_nxt = S_IDLE;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign in_tready = rst_n && (state_r == S_IDLE);

endmodule

`default_nettype wire

// File: src/encoder_speed_and_open_loop_drive_core.sv
// ----------------------------------------------------------------------------
// encoder_speed_and_open_loop_drive_core
// speed measurement and open-loop duty/direction drive for several motors
//
// in channel: one request per tick, set-speed or stop (action on in_tuser).
// out channel: one result per motor on a measuring tick or a stop, one
// result for a set-speed request; out_tlast marks the final result.
// cfg channel: pulses per turn, ready out of reset; the user must see
// it written only while idle, since the block itself does not enforce it.
// a non-measuring tick or an ignored request gives no result.
// a measuring tick runs one division per motor and a set-speed request
// one, on the shared 25-step serial divider (one quotient bit a cycle).
// one request is worked on at a time; the next is accepted once the last
// result sits in the output register.
// reset: pulses per turn 138, divider idle, speeds, peaks, duties, pins zero.
// stall: a held result stops the sequencer until the receiver takes it.
// ----------------------------------------------------------------------------
`default_nettype none

module encoder_speed_and_open_loop_drive_core #(
  parameter int NUM_MOTORS        = esod_pkg::NUM_MOTORS_DEF,
  parameter int TICKS_PER_MEASURE = esod_pkg::TICKS_DEF
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            in_tvalid,
  output logic                                 in_tready,
  // motor[1:0] target_speed[17:2] stop_mode[25:18] enc_count_0[41:26]
  // enc_count_1[57:42] enc_count_2[73:58] enc_count_3[89:74]
  input  wire logic [esod_pkg::IN_TDATA_W-1:0] in_tdata,
  // action[1:0]
  input  wire logic [esod_pkg::ACT_W-1:0]      in_tuser,
  output logic                                 out_tvalid,
  input  wire logic                            out_tready,
  // motor_index[1:0] duty[11:2] pin_a[12] pin_b[13] speed[29:14]
  // peak_speed[44:30] divide_error[45]
  output logic [esod_pkg::OUT_TDATA_W-1:0]     out_tdata,
  output logic                                 out_tlast,
  input  wire logic                            cfg_valid,
  output logic                                 cfg_ready,
  input  wire logic [esod_pkg::PPT_W-1:0]      cfg_data
);

  esod_pkg::cmd_t cmd;
  esod_pkg::sts_t sts;

  assign cfg_ready = rst_n;

  esod_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  esod_dp #(
    .NUM_MOTORS        (NUM_MOTORS),
    .TICKS_PER_MEASURE (TICKS_PER_MEASURE)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .sts        (sts),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .cfg_valid  (cfg_valid),
    .cfg_data   (cfg_data),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

endmodule

`default_nettype wire
